@@ rtl/sss_pkg.sv @@
// Package: shared constants and types for the scoped symbol stack.
package sss_pkg;

  localparam int STACK_ENTRIES_DEF = 64;
  localparam int NAME_CHARS_DEF    = 30;
  localparam int ADDR_BITS_DEF     = 16;
  localparam int NAME_BITS         = 240;

  localparam logic [2:0] REQ_PUSH  = 3'd0;
  localparam logic [2:0] REQ_POP   = 3'd1;
  localparam logic [2:0] REQ_FIND  = 3'd2;
  localparam logic [2:0] REQ_ENTER = 3'd3;
  localparam logic [2:0] REQ_LEAVE = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  // Classified request handed from front to back.
  typedef struct packed {
    logic [2:0]           req;
    logic [NAME_BITS-1:0] name;
    logic                 init;
    logic [12:0]          ty;
  } cmd_t;

  // Result transaction.
  typedef struct packed {
    logic [1:0]           status;
    logic [15:0]          addr;
    logic [12:0]          ty;
    logic                 init;
    logic [7:0]           level;
    logic [NAME_BITS-1:0] name;
    logic [15:0]          free;
  } res_t;

  // Clears every byte after the first zero byte or past nchars.
  function automatic logic [NAME_BITS-1:0] norm_name(input logic [NAME_BITS-1:0] raw,
                                                     input int nchars);
    logic [NAME_BITS-1:0] r;
    logic ended;
    r = '0;
    ended = 1'b0;
    for (int b = 0; b < 30; b++) begin
      if (b >= nchars || raw[b*8 +: 8] == 8'd0) ended = 1'b1;
      if (!ended) r[b*8 +: 8] = raw[b*8 +: 8];
    end
    return r;
  endfunction

endpackage

@@ rtl/sss_ram.sv @@
// Generic single-port-write RAM with registered read.
module sss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/sss_front.sv @@
// Front end: accepts request transactions, normalises the name, queues commands.
module sss_front #(
  parameter int NAME_CHARS = sss_pkg::NAME_CHARS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [2:0]                  req_type,
  input  logic [sss_pkg::NAME_BITS-1:0] raw_name,
  input  logic                        init_flag,
  input  logic                        base_kind,
  input  logic [3:0]                  pointer_depth,
  input  logic [7:0]                  block_count,
  output logic                        cmd_valid,
  input  logic                        cmd_take,
  output sss_pkg::cmd_t               cmd
);
  // two-entry queue
  sss_pkg::cmd_t q [2];
  logic          rd_ptr, wr_ptr;
  logic [1:0]    fill;
  logic          push, pop;

  assign in_stall  = (fill == 2'd2);
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (fill != 2'd0);
  assign pop       = cmd_valid && cmd_take;
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr].req  <= req_type;
      q[wr_ptr].name <= sss_pkg::norm_name(raw_name, NAME_CHARS);
      q[wr_ptr].init <= init_flag;
      q[wr_ptr].ty   <= {block_count, pointer_depth, base_kind};
    end
  end
endmodule

@@ rtl/sss_back.sv @@
// Back end: stack storage, scope walk and address allocation.
module sss_back #(
  parameter int STACK_ENTRIES = sss_pkg::STACK_ENTRIES_DEF,
  parameter int ADDR_BITS     = sss_pkg::ADDR_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_take,
  input  sss_pkg::cmd_t cmd,
  output logic          res_valid,
  input  logic          res_stall,
  output sss_pkg::res_t res
);
  localparam int IW = $clog2(STACK_ENTRIES);
  localparam int CW = IW + 1;
  localparam int EW = sss_pkg::NAME_BITS + ADDR_BITS + 13 + 1 + 8;

  typedef enum logic [2:0] {S_IDLE, S_RD, S_CHK, S_DONE} state_t;
  state_t state;

  logic [CW-1:0]        count, idx;
  logic [ADDR_BITS-1:0] next_free;
  logic [7:0]           scope;
  sss_pkg::cmd_t        cur;

  logic          we;
  logic [IW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;

  logic [sss_pkg::NAME_BITS-1:0] r_name;
  logic [ADDR_BITS-1:0]          r_addr;
  logic [12:0]                   r_ty;
  logic                          r_init;
  logic [7:0]                    r_level;
  assign {r_name, r_addr, r_ty, r_init, r_level} = rdata;

  sss_ram #(.WIDTH(EW), .DEPTH(STACK_ENTRIES)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // block_count * size, size -1 (unknown) or 4 (int)
  function automatic logic [ADDR_BITS-1:0] foot(input logic [12:0] ty, input logic add,
                                                input logic [ADDR_BITS-1:0] a);
    logic [ADDR_BITS+9:0] amt;
    amt = ty[0] ? {{ADDR_BITS{1'b0}}, ty[12:5], 2'b00}
                : {{(ADDR_BITS+2){1'b0}}, ty[12:5]};
    if (ty[0] == add) return a + amt[ADDR_BITS-1:0];
    return a - amt[ADDR_BITS-1:0];
  endfunction

  assign raddr = IW'(idx - CW'(1));
  assign waddr = count[IW-1:0];
  assign wdata = {cur.name, next_free, cur.ty, cur.init, scope};
  assign we    = (state == S_RD) && (cur.req == sss_pkg::REQ_PUSH)
                 && (count < CW'(STACK_ENTRIES));
  // next command only once the previous result has gone
  assign cmd_take = (state == S_IDLE) && cmd_valid && !res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      next_free <= '0;
      scope     <= '0;
      res_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd_take) begin
            cur   <= cmd;
            idx   <= count;
            state <= S_RD;
          end
        end
        S_RD: begin
          // RAM read of entry idx-1 is in flight
          res        <= '0;
          res.status <= sss_pkg::ST_OK;
          state      <= S_DONE;
          case (cur.req)
            sss_pkg::REQ_PUSH: begin
              if (count >= CW'(STACK_ENTRIES)) begin
                res.status <= sss_pkg::ST_FULL;
                res.level  <= scope;
              end else begin
                res.addr  <= 16'(next_free);
                res.ty    <= cur.ty;
                res.init  <= cur.init;
                res.level <= scope;
                res.name  <= cur.name;
                count     <= count + CW'(1);
                next_free <= foot(cur.ty, 1'b1, next_free);
              end
            end
            sss_pkg::REQ_POP: begin
              if (count == '0) begin
                res.status <= sss_pkg::ST_EMPTY;
                res.level  <= scope;
              end else state <= S_CHK;
            end
            sss_pkg::REQ_FIND, sss_pkg::REQ_LEAVE: begin
              if (idx == '0) begin
                if (cur.req == sss_pkg::REQ_FIND) begin
                  res.status <= sss_pkg::ST_NOTFOUND;
                  res.level  <= scope;
                end else begin
                  if (scope != 8'd0) scope <= scope - 8'd1;
                  res.level <= (scope != 8'd0) ? scope - 8'd1 : scope;
                end
              end else state <= S_CHK;
            end
            sss_pkg::REQ_ENTER: begin
              if (scope != 8'hFF) scope <= scope + 8'd1;
              res.level <= (scope != 8'hFF) ? scope + 8'd1 : scope;
            end
            default: res.level <= scope;
          endcase
        end
        S_CHK: begin
          state <= S_RD;
          case (cur.req)
            sss_pkg::REQ_POP: begin
              res.addr  <= 16'(r_addr);
              res.ty    <= r_ty;
              res.init  <= r_init;
              res.level <= r_level;
              res.name  <= r_name;
              count     <= count - CW'(1);
              next_free <= foot(r_ty, 1'b0, next_free);
              state     <= S_DONE;
            end
            sss_pkg::REQ_FIND: begin
              if (r_name == cur.name) begin
                res.addr  <= 16'(r_addr);
                res.ty    <= r_ty;
                res.init  <= r_init;
                res.level <= r_level;
                res.name  <= r_name;
                state     <= S_DONE;
              end else idx <= idx - CW'(1);
            end
            default: begin
              // leave scope: drop top while its level matches
              if (r_level == scope) begin
                count     <= count - CW'(1);
                next_free <= foot(r_ty, 1'b0, next_free);
                idx       <= idx - CW'(1);
              end else idx <= '0;
            end
          endcase
        end
        S_DONE: begin
          if (!res_valid || !res_stall) begin
            res_valid <= 1'b1;
            res.free  <= 16'(next_free);
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (res_valid && !res_stall && !(state == S_DONE)) res_valid <= 1'b0;
    end
  end
endmodule

@@ rtl/scoped_symbol_stack.sv @@
// Top level: scoped symbol stack with scope depth and frame address allocation.
//
// Usage:
//  - Request channel (valid/stall): req_type selects push, pop, lookup,
//    enter scope or leave scope; the name and type fields ride alongside.
//  - Result channel (valid/stall): exactly one result transaction per request,
//    in request order.
//  - A front end normalises the name (bytes after the first NUL cleared) and
//    queues up to two requests; the back end owns the stack RAM.
//  - Lookup and leave walk the stack from the top, with a RAM read then a
//    compare for each entry visited.
//  - One request at a time in the back end: the next is taken the cycle after
//    the previous result is accepted.
//  - Reset clears entry count, next free address and scope depth; the RAM
//    holds no reset value and only entries below the count are read.
//  - While the receiver stalls, the result holds; the queue keeps accepting
//    until it is full, then the request side is stalled.
module scoped_symbol_stack #(
  parameter int STACK_ENTRIES = sss_pkg::STACK_ENTRIES_DEF,
  parameter int NAME_CHARS    = sss_pkg::NAME_CHARS_DEF,
  parameter int ADDR_BITS     = sss_pkg::ADDR_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  req_type,
  input  logic [63:0] name_word_0,
  input  logic [63:0] name_word_1,
  input  logic [63:0] name_word_2,
  input  logic [47:0] name_word_3,
  input  logic        init_flag,
  input  logic        base_kind,
  input  logic [3:0]  pointer_depth,
  input  logic [7:0]  block_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [15:0] sym_address,
  output logic        sym_base_kind,
  output logic [3:0]  sym_pointer_depth,
  output logic [7:0]  sym_block_count,
  output logic        sym_initialized,
  output logic [7:0]  level_out,
  output logic [63:0] out_name_0,
  output logic [63:0] out_name_1,
  output logic [63:0] out_name_2,
  output logic [47:0] out_name_3,
  output logic [15:0] free_address
);
  logic          cmd_valid, cmd_take;
  sss_pkg::cmd_t cmd;
  sss_pkg::res_t res;

  sss_front #(.NAME_CHARS(NAME_CHARS)) u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type),
    .raw_name({name_word_3, name_word_2, name_word_1, name_word_0}),
    .init_flag(init_flag), .base_kind(base_kind), .pointer_depth(pointer_depth),
    .block_count(block_count), .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd)
  );

  sss_back #(.STACK_ENTRIES(STACK_ENTRIES), .ADDR_BITS(ADDR_BITS)) u_back (
    .clk(clk), .rst(rst), .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd),
    .res_valid(out_valid), .res_stall(out_stall), .res(res)
  );

  assign status            = res.status;
  assign sym_address       = res.addr;
  assign sym_base_kind     = res.ty[0];
  assign sym_pointer_depth = res.ty[4:1];
  assign sym_block_count   = res.ty[12:5];
  assign sym_initialized   = res.init;
  assign level_out         = res.level;
  assign out_name_0        = res.name[63:0];
  assign out_name_1        = res.name[127:64];
  assign out_name_2        = res.name[191:128];
  assign out_name_3        = res.name[239:192];
  assign free_address      = res.free;
endmodule
